### sv/dfhte_pkg.sv
package dfhte_pkg;

  localparam int LIT_W         = 8;
  localparam int LEN_W         = 9;
  localparam int DIST_W        = 16;
  localparam int FIELD_VALUE_W = 13;
  localparam int FIELD_BITS_W  = 4;
  localparam int MAX_FIELDS    = 4;
  localparam int FIELD_IDX_W   = 2;
  localparam int SYM_W         = 9;
  localparam int LEN_IDX_W     = 5;
  localparam int DIST_IDX_W    = 5;
  localparam int LEN_XVAL_W    = 5;
  localparam int DIST_XVAL_W   = 13;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = 1;

  localparam logic CMD_LITERAL = 1'b0;
  localparam logic CMD_MATCH   = 1'b1;

  localparam int LEN_CODES  = 29;
  localparam int DIST_CODES = 30;

  localparam logic [SYM_W-1:0] SYM_LIT_LOW_END = 9'd144;
  localparam logic [SYM_W-1:0] SYM_LIT_END     = 9'd256;
  localparam logic [SYM_W-1:0] SYM_LEN_LOW_END = 9'd280;
  localparam logic [SYM_W-1:0] SYM_LEN_FIRST   = 9'd257;

  localparam logic [LEN_W-1:0] LEN_LOW [LEN_CODES] = '{
    9'd3,   9'd4,   9'd5,   9'd6,   9'd7,   9'd8,   9'd9,   9'd10,  9'd11,  9'd13,
    9'd15,  9'd17,  9'd19,  9'd23,  9'd27,  9'd31,  9'd35,  9'd43,  9'd51,  9'd59,
    9'd67,  9'd83,  9'd99,  9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };

  localparam logic [2:0] LEN_XBITS [LEN_CODES] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
    3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd0
  };

  localparam logic [DIST_W-1:0] DIST_LOW [DIST_CODES] = '{
    16'd1,     16'd2,     16'd3,     16'd4,     16'd5,     16'd7,
    16'd9,     16'd13,    16'd17,    16'd25,    16'd33,    16'd49,
    16'd65,    16'd97,    16'd129,   16'd193,   16'd257,   16'd385,
    16'd513,   16'd769,   16'd1025,  16'd1537,  16'd2049,  16'd3073,
    16'd4097,  16'd6145,  16'd8193,  16'd12289, 16'd16385, 16'd24577
  };

  localparam logic [3:0] DIST_XBITS [DIST_CODES] = '{
    4'd0, 4'd0, 4'd0,  4'd0,  4'd1,  4'd1,  4'd2,  4'd2,  4'd3,  4'd3,
    4'd4, 4'd4, 4'd5,  4'd5,  4'd6,  4'd6,  4'd7,  4'd7,  4'd8,  4'd8,
    4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

  localparam logic [DIST_W-1:0] DIST_MAX = 16'd32768;

  typedef struct packed {
    logic [FIELD_VALUE_W-1:0] value;
    logic [FIELD_BITS_W-1:0]  bits;
  } field_t;

  // Fields of one token in wire order; last_idx marks the final one.
  typedef struct packed {
    field_t [MAX_FIELDS-1:0]  fields;
    logic [FIELD_IDX_W-1:0]   last_idx;
  } job_t;

  function automatic logic [4:0] rev5(input logic [4:0] v);
    logic [4:0] r;
    for (int k = 0; k < 5; k++) r[k] = v[4-k];
    return r;
  endfunction

  function automatic logic [6:0] rev7(input logic [6:0] v);
    logic [6:0] r;
    for (int k = 0; k < 7; k++) r[k] = v[6-k];
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

  function automatic logic [8:0] rev9(input logic [8:0] v);
    logic [8:0] r;
    for (int k = 0; k < 9; k++) r[k] = v[8-k];
    return r;
  endfunction

  // Fixed literal/length code, reversed for LSB-first packing.
  function automatic field_t fixed_ll(input logic [SYM_W-1:0] sym);
    field_t     f;
    logic [8:0] off;
    if (sym < SYM_LIT_LOW_END) begin
      f.value = {5'd0, rev8(8'h30 + sym[7:0])};
      f.bits  = 4'd8;
    end else if (sym < SYM_LIT_END) begin
      off     = sym - SYM_LIT_LOW_END;
      f.value = {4'd0, rev9(9'h190 + off)};
      f.bits  = 4'd9;
    end else if (sym < SYM_LEN_LOW_END) begin
      off     = sym - SYM_LIT_END;
      f.value = {6'd0, rev7(off[6:0])};
      f.bits  = 4'd7;
    end else begin
      off     = sym - SYM_LEN_LOW_END;
      f.value = {5'd0, rev8({5'b11000, off[2:0]})};
      f.bits  = 4'd8;
    end
    return f;
  endfunction

  // Lengths below the first base fall on code 0, above 258 on the last code.
  function automatic logic [LEN_IDX_W-1:0] len_index(input logic [LEN_W-1:0] len);
    logic [LEN_IDX_W-1:0] li;
    li = '0;
    for (int i = 1; i < LEN_CODES; i++) begin
      if (len >= LEN_LOW[i]) li = LEN_IDX_W'(i);
    end
    return li;
  endfunction

  function automatic logic [DIST_IDX_W-1:0] dist_index(input logic [DIST_W-1:0] distance);
    logic [DIST_IDX_W-1:0] di;
    di = '0;
    for (int i = 1; i < DIST_CODES; i++) begin
      if (distance >= DIST_LOW[i]) di = DIST_IDX_W'(i);
    end
    return di;
  endfunction

endpackage

### sv/dfhte_token_if.sv
interface dfhte_token_if;
  import dfhte_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [LIT_W-1:0]  literal_byte;
  logic [LEN_W-1:0]  match_length;
  logic [DIST_W-1:0] match_distance;

  modport source (
    output valid, cmd, literal_byte, match_length, match_distance,
    input  ready
  );

  modport sink (
    input  valid, cmd, literal_byte, match_length, match_distance,
    output ready
  );
endinterface

### sv/dfhte_field_if.sv
interface dfhte_field_if;
  import dfhte_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FIELD_VALUE_W-1:0] field_value;
  logic [FIELD_BITS_W-1:0]  field_bits;
  logic                     last_field;

  modport source (
    output valid, field_value, field_bits, last_field,
    input  ready
  );

  modport sink (
    input  valid, field_value, field_bits, last_field,
    output ready
  );
endinterface

### sv/deflate_fixed_huffman_token_encoder_top.sv
// Channel  Role    Payload
// token    sink    cmd, literal_byte, match_length, match_distance
// field    source  field_value, field_bits, last_field
//
// One field leaves per cycle from the output register while the field output is not
// stalled, so a literal gives 1 field and a match 2 to 4 fields (length code, optional
// length extra, distance code, optional distance extra); that register sets the rate.
// A token's first field passes through the queue, then the output register.
// Synchronous rst empties the two-entry token queue and the output stage.
// A stalled field output holds its value; tokens keep entering until the queue fills.
module deflate_fixed_huffman_token_encoder_top (
  input  logic          clk,
  input  logic          rst,
  dfhte_token_if.sink   token,
  dfhte_field_if.source field
);
  import dfhte_pkg::*;

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // Classify the token and build all its wire fields in one go.
  dfhte_front u_front (
    .token      (token),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Hold finished jobs so the input side rides out short output stalls.
  dfhte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_job    (push_job),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_job   (pop_job)
  );

  // Step through the head job, one field per item, and drop it after the last.
  dfhte_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop_valid),
    .in_ready (pop_ready),
    .in_job   (pop_job),
    .field    (field)
  );

endmodule

### sv/dfhte_front.sv
module dfhte_front (
  dfhte_token_if.sink      token,
  output logic             push_valid,
  input  logic             push_ready,
  output dfhte_pkg::job_t  push_job
);
  import dfhte_pkg::*;

  logic [DIST_W-1:0]      dist_sat;
  logic [LEN_IDX_W-1:0]   li;
  logic [DIST_IDX_W-1:0]  di;
  logic [LEN_W-1:0]       len_diff;
  logic [DIST_W-1:0]      dist_diff;
  logic                   has_lx;
  logic                   has_dx;
  field_t                 len_code;
  field_t                 len_xfield;
  field_t                 dist_code;
  field_t                 dist_xfield;

  assign push_valid  = token.valid;
  assign token.ready = push_ready;

  // Saturate distance into 1..32768.
  always_comb begin
    if (token.match_distance == '0) begin
      dist_sat = DIST_W'(1);
    end else if (token.match_distance > DIST_MAX) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = token.match_distance;
    end
  end

  always_comb begin
    li        = len_index(token.match_length);
    di        = dist_index(dist_sat);
    len_diff  = token.match_length - LEN_LOW[li];
    dist_diff = dist_sat - DIST_LOW[di];
    has_lx    = (LEN_XBITS[li] != '0);
    has_dx    = (DIST_XBITS[di] != '0);

    len_code          = fixed_ll(SYM_LEN_FIRST + SYM_W'(li));
    len_xfield.value  = {8'd0, len_diff[LEN_XVAL_W-1:0]};
    len_xfield.bits   = {1'b0, LEN_XBITS[li]};
    dist_code.value   = {8'd0, rev5(di)};
    dist_code.bits    = 4'd5;
    dist_xfield.value = dist_diff[DIST_XVAL_W-1:0];
    dist_xfield.bits  = DIST_XBITS[di];
  end

  always_comb begin
    push_job = '0;
    if (token.cmd == CMD_LITERAL) begin
      push_job.fields[0] = fixed_ll({1'b0, token.literal_byte});
      push_job.last_idx  = 2'd0;
    end else begin
      push_job.fields[0] = len_code;
      unique case ({has_lx, has_dx})
        2'b00: begin
          push_job.fields[1] = dist_code;
          push_job.last_idx  = 2'd1;
        end
        2'b10: begin
          push_job.fields[1] = len_xfield;
          push_job.fields[2] = dist_code;
          push_job.last_idx  = 2'd2;
        end
        2'b01: begin
          push_job.fields[1] = dist_code;
          push_job.fields[2] = dist_xfield;
          push_job.last_idx  = 2'd2;
        end
        default: begin
          push_job.fields[1] = len_xfield;
          push_job.fields[2] = dist_code;
          push_job.fields[3] = dist_xfield;
          push_job.last_idx  = 2'd3;
        end
      endcase
    end
  end

endmodule

### sv/dfhte_queue.sv
module dfhte_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dfhte_pkg::job_t  in_job,
  output logic             out_valid,
  input  logic             out_ready,
  output dfhte_pkg::job_t  out_job
);
  import dfhte_pkg::*;

  job_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   push;
  logic                   pop;

  assign in_ready  = (count != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_job   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (QUEUE_PTR_W + 1)'(1);
        2'b01:   count <= count - (QUEUE_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/dfhte_back.sv
module dfhte_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dfhte_pkg::job_t  in_job,
  dfhte_field_if.source    field
);
  import dfhte_pkg::*;

  logic [FIELD_IDX_W-1:0] idx;
  logic                   out_valid;
  field_t                 out_field;
  logic                   out_last;
  logic                   load;
  logic                   head_last;

  // Advance one field per cycle whenever the output register frees up.
  assign load      = in_valid && (!out_valid || field.ready);
  assign head_last = (idx == in_job.last_idx);
  assign in_ready  = load && head_last;

  assign field.valid       = out_valid;
  assign field.field_value = out_field.value;
  assign field.field_bits  = out_field.bits;
  assign field.last_field  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= head_last ? '0 : idx + FIELD_IDX_W'(1);
    end else if (field.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_field <= in_job.fields[idx];
      out_last  <= head_last;
    end
  end

endmodule
